// ----- hdl/mdb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_pkg: shared types and constants of the multi-pin debouncer
// Field widths, opcodes, register indexes and the lane interface structs.
// ----------------------------------------------------------------------------
package mdb_pkg;

  localparam int unsigned DEFAULT_PINS = 8;
  localparam int unsigned FIELD_W      = 8;   // pin_levels, clear_mask, outputs
  localparam int unsigned OP_W         = 2;
  localparam int unsigned CNT_W        = 8;   // debounce_count and tick counters
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;

  localparam logic [CNT_W-1:0] DEBOUNCE_COUNT_RST = CNT_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_CAPTURE = 2'd1,
    OP_CLEAR   = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_COUNT = 2'd0,
    CFG_START_CHANGED  = 2'd1
  } cfg_idx_e;

  // Per-lane command for one accepted transaction
  typedef struct packed {
    logic    accept;
    opcode_e op;
    logic    sample;
    logic    clear;
  } mdb_lane_cmd_t;

  // Per-lane state after the transaction
  typedef struct packed {
    logic stable;
    logic changed;
  } mdb_lane_res_t;

endpackage

// ----- hdl/mdb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_in_if / mdb_out_if: valid/ready channels of the multi-pin debouncer
// Input carries opcode, raw pin levels and clear mask; output carries the
// debounced levels and changed flags.
// ----------------------------------------------------------------------------
interface mdb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] pin_levels;
  logic [7:0] clear_mask;

  modport source (output valid, output opcode, output pin_levels, output clear_mask,
                  input ready);
  modport sink   (input valid, input opcode, input pin_levels, input clear_mask,
                  output ready);
endinterface

interface mdb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] stable_levels;
  logic [7:0] changed_flags;

  modport source (output valid, output stable_levels, output changed_flags,
                  input ready);
  modport sink   (input valid, input stable_levels, input changed_flags,
                  output ready);
endinterface

// ----- hdl/mdb_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_lane: debouncer core for one pin
// Holds stable/last-seen level, confirm state, tick counter and changed flag.
// Presents the post-transaction state combinationally to the merge stage.
// ----------------------------------------------------------------------------
module mdb_lane
  import mdb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mdb_lane_cmd_t    cmd_i,
  input  logic [CNT_W-1:0] debounce_count_i,
  input  logic             start_changed_i,
  output mdb_lane_res_t    res_o
);

  logic             stable_q, stable_d;
  logic             last_q, last_d;
  logic             confirm_q, confirm_d;
  logic             changed_q, changed_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = cnt_q + CNT_W'(1);

  always_comb begin
    stable_d  = stable_q;
    last_d    = last_q;
    confirm_d = confirm_q;
    changed_d = changed_q;
    cnt_d     = cnt_q;
    if (cmd_i.accept) begin
      unique case (cmd_i.op)
        OP_TICK: begin
          if (!confirm_q) begin
            // start confirming on an edge against the last-seen level
            if (last_q != cmd_i.sample) begin
              last_d    = cmd_i.sample;
              confirm_d = 1'b1;
            end
          end else begin
            cnt_d = cnt_inc;
            if (cnt_inc >= debounce_count_i) begin
              cnt_d     = '0;
              confirm_d = 1'b0;
              if (last_q == cmd_i.sample) begin
                stable_d  = cmd_i.sample;
                changed_d = 1'b1;
              end else begin
                last_d = cmd_i.sample;
              end
            end
          end
        end
        OP_CAPTURE: begin
          // leave confirm state and counter alone
          stable_d  = cmd_i.sample;
          last_d    = cmd_i.sample;
          changed_d = start_changed_i;
        end
        OP_CLEAR: begin
          if (cmd_i.clear) begin
            changed_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= 1'b0;
      last_q    <= 1'b0;
      confirm_q <= 1'b0;
      changed_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      stable_q  <= stable_d;
      last_q    <= last_d;
      confirm_q <= confirm_d;
      changed_q <= changed_d;
      cnt_q     <= cnt_d;
    end
  end

  assign res_o.stable  = stable_d;
  assign res_o.changed = changed_d;

endmodule

// ----- hdl/mdb_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_merge: result merge and output register
// Packs the first lanes into the 8-bit result fields and holds them in an
// output register until the sink takes the transaction.
// ----------------------------------------------------------------------------
module mdb_merge
  import mdb_pkg::*;
#(
  parameter int unsigned PINS = DEFAULT_PINS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  mdb_lane_res_t [PINS-1:0] lane_res_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [FIELD_W-1:0]       stable_levels_o,
  output logic [FIELD_W-1:0]       changed_flags_o
);

  logic               valid_q, valid_d;
  logic [FIELD_W-1:0] stable_q;
  logic [FIELD_W-1:0] changed_q;
  logic [FIELD_W-1:0] stable_w;
  logic [FIELD_W-1:0] changed_w;

  for (genvar b = 0; b < FIELD_W; b++) begin : g_bit
    if (b < PINS) begin : g_lane
      assign stable_w[b]  = lane_res_i[b].stable;
      assign changed_w[b] = lane_res_i[b].changed;
    end else begin : g_pad
      assign stable_w[b]  = 1'b0;
      assign changed_w[b] = 1'b0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      stable_q  <= stable_w;
      changed_q <= changed_w;
    end
  end

  assign out_valid_o     = valid_q;
  assign stable_levels_o = stable_q;
  assign changed_flags_o = changed_q;

endmodule

// ----- hdl/multi_pin_debouncer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pin_debouncer_top: bank of pin debouncers sharing one scan tick
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   opcode, pin_levels, clear_mask
//   out_o    out  valid/ready   stable_levels, changed_flags
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_wdata_i (write only)
//
// One transaction per cycle while in_i.ready is high; every pin lane updates in the accepting cycle.
// The result appears in the output register in the cycle after acceptance.
// in_i.ready drops only while the output register is full and not taken.
// Reset clears all lane state, sets debounce_count to 1, start_changed to 0.
// ----------------------------------------------------------------------------
module multi_pin_debouncer_top
  import mdb_pkg::*;
#(
  parameter int unsigned PINS = DEFAULT_PINS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mdb_in_if.sink                in_i,
  mdb_out_if.source             out_o
);

  logic [CNT_W-1:0]         debounce_count_q, debounce_count_d;
  logic                     start_changed_q, start_changed_d;
  logic                     accept;
  mdb_lane_res_t [PINS-1:0] lane_res;

  // configuration registers
  always_comb begin
    debounce_count_d = debounce_count_q;
    start_changed_d  = start_changed_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE_COUNT: debounce_count_d = cfg_wdata_i[CNT_W-1:0];
        CFG_START_CHANGED:  start_changed_d  = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_count_q <= DEBOUNCE_COUNT_RST;
      start_changed_q  <= 1'b0;
    end else begin
      debounce_count_q <= debounce_count_d;
      start_changed_q  <= start_changed_d;
    end
  end

  // accept whenever the output register is free or being drained
  assign in_i.ready = !out_o.valid || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  for (genvar i = 0; i < PINS; i++) begin : g_lane
    mdb_lane_cmd_t cmd;
    assign cmd.accept = accept;
    assign cmd.op     = opcode_e'(in_i.opcode);
    if (i < FIELD_W) begin : g_in
      assign cmd.sample = in_i.pin_levels[i];
      assign cmd.clear  = in_i.clear_mask[i];
    end else begin : g_pad
      // pins beyond the field width see a low level and no clear
      assign cmd.sample = 1'b0;
      assign cmd.clear  = 1'b0;
    end

    mdb_lane u_lane (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .cmd_i            (cmd),
      .debounce_count_i (debounce_count_q),
      .start_changed_i  (start_changed_q),
      .res_o            (lane_res[i])
    );
  end

  mdb_merge #(
    .PINS (PINS)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .lane_res_i      (lane_res),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .stable_levels_o (out_o.stable_levels),
    .changed_flags_o (out_o.changed_flags)
  );

endmodule

// ----- hdl/mdb_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_chk: port-level checks for the multi-pin debouncer
// Watches both channels of the top level; bound to it below.
// ----------------------------------------------------------------------------
module mdb_chk
  import mdb_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [OP_W-1:0]    in_opcode_i,
  input logic [FIELD_W-1:0] in_clear_mask_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [FIELD_W-1:0] out_stable_levels_i,
  input logic [FIELD_W-1:0] out_changed_flags_i
);

  // every accepted transaction shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result after accepted transaction");

  // a full, stalled output register blocks new transactions
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input accepted while result stalled");

  // clearing every flag leaves no changed flag set
  a_full_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_opcode_i == OP_CLEAR && in_clear_mask_i == '1
    |=> out_changed_flags_i == '0)
    else $error("changed flag survived full clear");

  // held result keeps its payload
  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i
    |=> $stable(out_stable_levels_i) && $stable(out_changed_flags_i))
    else $error("stalled result changed");

endmodule

bind multi_pin_debouncer_top mdb_chk u_mdb_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .in_opcode_i         (in_i.opcode),
  .in_clear_mask_i     (in_i.clear_mask),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_stable_levels_i (out_o.stable_levels),
  .out_changed_flags_i (out_o.changed_flags)
);
